[design/sia_pkg.sv]
// Shared types and constants for the spatial inertia apply block.
// Used by sia_mul and spatial_inertia_apply; depends on nothing.
`timescale 1ns / 1ps

package sia_pkg;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int HALF_W      = 32;

  typedef enum logic {
    OP_PRODUCT = 1'b0,
    OP_BIAS    = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MASS          = 3'd0,
    REG_MOMENT_X      = 3'd1,
    REG_MOMENT_Y      = 3'd2,
    REG_MOMENT_Z      = 3'd3,
    REG_INERTIA_XX_YY = 3'd4,
    REG_INERTIA_ZZ_XY = 3'd5,
    REG_INERTIA_XZ_YZ = 3'd6
  } cfg_reg_t;

  // cross product a x b: term k is a[CROSS_A[k]] * b[CROSS_B[k]],
  // component i = term 2i - term 2i+1
  localparam int unsigned CROSS_A [6] = '{1, 2, 2, 0, 0, 1};
  localparam int unsigned CROSS_B [6] = '{2, 1, 0, 2, 1, 0};

  typedef struct packed {
    logic part;
    logic prod;
  } mul_en_t;

endpackage

[design/sia_mul.sv]
// Two-stage fixed-point multiplier: split partial products, then sum,
// arithmetic shift and saturate. Depends on sia_pkg.
`timescale 1ns / 1ps

module sia_mul #(
  parameter int DW = 32,
  parameter int FW = 16
) (
  input  logic                 clk,
  input  sia_pkg::mul_en_t     en,
  input  logic signed [DW-1:0] a,
  input  logic signed [DW-1:0] b,
  output logic signed [DW-1:0] q,
  output logic                 ovf
);

  localparam int H  = DW / 2;
  localparam int HW = DW - H;
  localparam int PW = 2 * DW;
  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [DW+H:0]    plo_r, plo_nxt;
  logic signed [DW+HW-1:0] phi_r, phi_nxt;
  logic signed [PW-1:0]    prod;
  logic [DW-FW:0]          top;
  logic signed [DW-1:0]    q_r, q_nxt;
  logic                    ovf_r, ovf_nxt;

  always_comb begin
    plo_nxt = (DW+H+1)'(a) * (DW+H+1)'($signed({1'b0, b[H-1:0]}));
    phi_nxt = (DW+HW)'(a) * (DW+HW)'($signed(b[DW-1:H]));
  end

  always_comb begin
    prod    = (PW'(phi_r) <<< H) + PW'(plo_r);
    top     = prod[PW-1:FW+DW-1];
    ovf_nxt = !((&top) || !(|top));
    if (ovf_nxt) begin
      q_nxt = prod[PW-1] ? VMIN : VMAX;
    end else begin
      q_nxt = prod[FW+DW-1:FW];
    end
  end

  always_ff @(posedge clk) begin
    if (en.part) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
    if (en.prod) begin
      q_r   <= q_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign q   = q_r;
  assign ovf = ovf_r;

endmodule

[design/spatial_inertia_apply.sv]
// Spatial inertia of one rigid body applied to a motion vector (top level).
// Depends on sia_pkg and sia_mul.
//
// Usage: the body (mass, first moment c, symmetric inertia I) is written
// through cfg_we/cfg_index/cfg_data while the block is idle. Each input
// transaction carries an opcode and a motion vector (lin, ang); opcode
// OP_PRODUCT gives the spatial inertia times the vector, OP_BIAS gives the
// bias wrench. Every input transaction yields exactly one output transaction
// with force, torque and an overflow flag set by any saturation on the way.
// From input acceptance to the output register an item passes through
// two multiply levels of three stages each (partial products, shift and
// saturate, vector sums) and a final add stage that is the output register.
// Throughput is one transaction per cycle while the receiver does not
// stall, set by one multiplier per product term in each level.
// Reset clears the configuration to zero and empties the pipeline.
// When the receiver stalls, the result stays in the output register and
// items behind it close up any gaps; in_stall rises once all seven stages
// hold an item.
`timescale 1ns / 1ps

module spatial_inertia_apply #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sia_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sia_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic signed [DATA_WIDTH-1:0]        in_lin_x,
  input  logic signed [DATA_WIDTH-1:0]        in_lin_y,
  input  logic signed [DATA_WIDTH-1:0]        in_lin_z,
  input  logic signed [DATA_WIDTH-1:0]        in_ang_x,
  input  logic signed [DATA_WIDTH-1:0]        in_ang_y,
  input  logic signed [DATA_WIDTH-1:0]        in_ang_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [DATA_WIDTH-1:0]        out_force_x,
  output logic signed [DATA_WIDTH-1:0]        out_force_y,
  output logic signed [DATA_WIDTH-1:0]        out_force_z,
  output logic signed [DATA_WIDTH-1:0]        out_torque_x,
  output logic signed [DATA_WIDTH-1:0]        out_torque_y,
  output logic signed [DATA_WIDTH-1:0]        out_torque_z,
  output logic                                out_overflow
);

  localparam int DW = DATA_WIDTH;
  localparam int NS = 7;
  localparam int XW = (DW + 2 > sia_pkg::HALF_W + 1) ? DW + 2 : sia_pkg::HALF_W + 1;
  localparam logic signed [XW-1:0] VMAX_X = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [XW-1:0] VMIN_X = ~VMAX_X;

  typedef logic signed [DW-1:0] word_t;

  function automatic logic [DW:0] sat_fn(input logic signed [XW-1:0] x);
    logic [DW:0] r;
    if (x > VMAX_X) begin
      r = {1'b1, VMAX_X[DW-1:0]};
    end else if (x < VMIN_X) begin
      r = {1'b1, VMIN_X[DW-1:0]};
    end else begin
      r = {1'b0, x[DW-1:0]};
    end
    return r;
  endfunction

  // ---------------- configuration ----------------
  word_t       mass_r;
  word_t       mom_r [3];
  word_t       inr_r [6];  // xx, yy, zz, xy, xz, yz
  logic [2:0]  inr_ovf_r;
  logic [DW:0] cfg_hi, cfg_lo;
  word_t       imat [3][3];

  assign cfg_hi = sat_fn(XW'($signed(cfg_data[2*sia_pkg::HALF_W-1:sia_pkg::HALF_W])));
  assign cfg_lo = sat_fn(XW'($signed(cfg_data[sia_pkg::HALF_W-1:0])));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r    <= '0;
      mom_r     <= '{default: '0};
      inr_r     <= '{default: '0};
      inr_ovf_r <= '0;
    end else if (cfg_we) begin
      unique case (sia_pkg::cfg_reg_t'(cfg_index))
        sia_pkg::REG_MASS:     mass_r   <= cfg_data[DW-1:0];
        sia_pkg::REG_MOMENT_X: mom_r[0] <= cfg_data[DW-1:0];
        sia_pkg::REG_MOMENT_Y: mom_r[1] <= cfg_data[DW-1:0];
        sia_pkg::REG_MOMENT_Z: mom_r[2] <= cfg_data[DW-1:0];
        sia_pkg::REG_INERTIA_XX_YY: begin
          inr_r[0]     <= cfg_hi[DW-1:0];
          inr_r[1]     <= cfg_lo[DW-1:0];
          inr_ovf_r[0] <= cfg_hi[DW] | cfg_lo[DW];
        end
        sia_pkg::REG_INERTIA_ZZ_XY: begin
          inr_r[2]     <= cfg_hi[DW-1:0];
          inr_r[3]     <= cfg_lo[DW-1:0];
          inr_ovf_r[1] <= cfg_hi[DW] | cfg_lo[DW];
        end
        sia_pkg::REG_INERTIA_XZ_YZ: begin
          inr_r[4]     <= cfg_hi[DW-1:0];
          inr_r[5]     <= cfg_lo[DW-1:0];
          inr_ovf_r[2] <= cfg_hi[DW] | cfg_lo[DW];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    imat[0][0] = inr_r[0];
    imat[0][1] = inr_r[3];
    imat[0][2] = inr_r[4];
    imat[1][0] = inr_r[3];
    imat[1][1] = inr_r[1];
    imat[1][2] = inr_r[5];
    imat[2][0] = inr_r[4];
    imat[2][1] = inr_r[5];
    imat[2][2] = inr_r[2];
  end

  // ---------------- pipeline control ----------------
  logic [NS:1] v_r, v_nxt, en;
  sia_pkg::mul_en_t en_l1, en_l2;

  always_comb begin
    en[NS] = !v_r[NS] || !out_stall;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[1] = en[1] ? in_valid : v_r[1];
    for (int k = 2; k <= NS; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = v_r[NS];
  assign en_l1     = '{part: en[1], prod: en[2]};
  assign en_l2     = '{part: en[4], prod: en[5]};

  // ---------------- level 1: w x v, c x w, I w ----------------
  word_t lin_in [3];
  word_t ang_in [3];
  word_t wv_q [6];
  word_t cw_q [6];
  word_t iw_q [9];
  logic [5:0] wv_o, cw_o;
  logic [8:0] iw_o;

  assign lin_in = '{in_lin_x, in_lin_y, in_lin_z};
  assign ang_in = '{in_ang_x, in_ang_y, in_ang_z};

  for (genvar g = 0; g < 6; g++) begin : g_l1x
    sia_mul #(.DW(DW), .FW(FRAC_BITS)) u_wv (
      .clk (clk), .en (en_l1),
      .a (ang_in[sia_pkg::CROSS_A[g]]), .b (lin_in[sia_pkg::CROSS_B[g]]),
      .q (wv_q[g]), .ovf (wv_o[g])
    );
    sia_mul #(.DW(DW), .FW(FRAC_BITS)) u_cw (
      .clk (clk), .en (en_l1),
      .a (mom_r[sia_pkg::CROSS_A[g]]), .b (ang_in[sia_pkg::CROSS_B[g]]),
      .q (cw_q[g]), .ovf (cw_o[g])
    );
  end

  for (genvar g = 0; g < 9; g++) begin : g_l1i
    sia_mul #(.DW(DW), .FW(FRAC_BITS)) u_iw (
      .clk (clk), .en (en_l1),
      .a (imat[g/3][g%3]), .b (ang_in[g%3]),
      .q (iw_q[g]), .ovf (iw_o[g])
    );
  end

  // side data, stages 1 and 2
  sia_pkg::op_t op1_r, op2_r;
  word_t lin1_r [3];
  word_t ang1_r [3];
  word_t lin2_r [3];
  word_t ang2_r [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      op1_r  <= sia_pkg::op_t'(in_opcode);
      lin1_r <= lin_in;
      ang1_r <= ang_in;
    end
    if (en[2]) begin
      op2_r  <= op1_r;
      lin2_r <= lin1_r;
      ang2_r <= ang1_r;
    end
  end

  // stage 3: level 1 sums
  sia_pkg::op_t op3_r;
  word_t u3_r [3], u3_nxt [3];
  word_t cw3_r [3], cw3_nxt [3];
  word_t iw3_r [3], iw3_nxt [3];
  word_t ang3_r [3];
  logic  ovf3_r, ovf3_nxt;

  always_comb begin
    logic [DW:0] sd, sc, si;
    logic        fd, fc, fi;
    fd = |wv_o;
    fc = |cw_o;
    fi = (|iw_o) | (|inr_ovf_r);
    for (int i = 0; i < 3; i++) begin
      sd = sat_fn(XW'(wv_q[2*i]) - XW'(wv_q[2*i+1]));
      sc = sat_fn(XW'(cw_q[2*i]) - XW'(cw_q[2*i+1]));
      si = sat_fn(XW'(iw_q[3*i]) + XW'(iw_q[3*i+1]) + XW'(iw_q[3*i+2]));
      fd = fd | sd[DW];
      fc = fc | sc[DW];
      fi = fi | si[DW];
      u3_nxt[i]  = (op2_r == sia_pkg::OP_BIAS) ? word_t'(sd[DW-1:0]) : lin2_r[i];
      cw3_nxt[i] = sc[DW-1:0];
      iw3_nxt[i] = si[DW-1:0];
    end
    ovf3_nxt = fc | fi | ((op2_r == sia_pkg::OP_BIAS) & fd);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      op3_r  <= op2_r;
      u3_r   <= u3_nxt;
      cw3_r  <= cw3_nxt;
      iw3_r  <= iw3_nxt;
      ang3_r <= ang2_r;
      ovf3_r <= ovf3_nxt;
    end
  end

  // ---------------- level 2: m u, c x u, w x (c x w), w x (I w) ----------------
  word_t mv_q [3];
  word_t cu_q [6];
  word_t wc_q [6];
  word_t wi_q [6];
  logic [2:0] mv_o;
  logic [5:0] cu_o, wc_o, wi_o;

  for (genvar g = 0; g < 3; g++) begin : g_l2m
    sia_mul #(.DW(DW), .FW(FRAC_BITS)) u_mv (
      .clk (clk), .en (en_l2),
      .a (mass_r), .b (u3_r[g]),
      .q (mv_q[g]), .ovf (mv_o[g])
    );
  end

  for (genvar g = 0; g < 6; g++) begin : g_l2x
    sia_mul #(.DW(DW), .FW(FRAC_BITS)) u_cu (
      .clk (clk), .en (en_l2),
      .a (mom_r[sia_pkg::CROSS_A[g]]), .b (u3_r[sia_pkg::CROSS_B[g]]),
      .q (cu_q[g]), .ovf (cu_o[g])
    );
    sia_mul #(.DW(DW), .FW(FRAC_BITS)) u_wc (
      .clk (clk), .en (en_l2),
      .a (ang3_r[sia_pkg::CROSS_A[g]]), .b (cw3_r[sia_pkg::CROSS_B[g]]),
      .q (wc_q[g]), .ovf (wc_o[g])
    );
    sia_mul #(.DW(DW), .FW(FRAC_BITS)) u_wi (
      .clk (clk), .en (en_l2),
      .a (ang3_r[sia_pkg::CROSS_A[g]]), .b (iw3_r[sia_pkg::CROSS_B[g]]),
      .q (wi_q[g]), .ovf (wi_o[g])
    );
  end

  // side data, stages 4 and 5
  sia_pkg::op_t op4_r, op5_r;
  word_t cw4_r [3];
  word_t iw4_r [3];
  word_t cw5_r [3];
  word_t iw5_r [3];
  logic  ovf4_r, ovf5_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      op4_r  <= op3_r;
      cw4_r  <= cw3_r;
      iw4_r  <= iw3_r;
      ovf4_r <= ovf3_r;
    end
    if (en[5]) begin
      op5_r  <= op4_r;
      cw5_r  <= cw4_r;
      iw5_r  <= iw4_r;
      ovf5_r <= ovf4_r;
    end
  end

  // stage 6: level 2 sums and opcode select
  word_t a6_r [3], a6_nxt [3];
  word_t c6_r [3], c6_nxt [3];
  word_t b6_r [3], b6_nxt [3];
  word_t d6_r [3], d6_nxt [3];
  logic  ovf6_r, ovf6_nxt;

  always_comb begin
    logic [DW:0] sa, sb, si;
    logic        fa, fb;
    logic        bias;
    bias = (op5_r == sia_pkg::OP_BIAS);
    fa   = (|mv_o) | (|cu_o);
    fb   = (|wc_o) | (|wi_o);
    for (int i = 0; i < 3; i++) begin
      sa = sat_fn(XW'(cu_q[2*i]) - XW'(cu_q[2*i+1]));
      sb = sat_fn(XW'(wc_q[2*i]) - XW'(wc_q[2*i+1]));
      si = sat_fn(XW'(wi_q[2*i]) - XW'(wi_q[2*i+1]));
      fa = fa | sa[DW];
      fb = fb | sb[DW] | si[DW];
      a6_nxt[i] = mv_q[i];
      c6_nxt[i] = sa[DW-1:0];
      b6_nxt[i] = bias ? word_t'(sb[DW-1:0]) : cw5_r[i];
      d6_nxt[i] = bias ? word_t'(si[DW-1:0]) : iw5_r[i];
    end
    ovf6_nxt = ovf5_r | fa | (bias & fb);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      a6_r   <= a6_nxt;
      c6_r   <= c6_nxt;
      b6_r   <= b6_nxt;
      d6_r   <= d6_nxt;
      ovf6_r <= ovf6_nxt;
    end
  end

  // stage 7: force = a - b, torque = c + d; output register
  word_t f7_r [3], f7_nxt [3];
  word_t t7_r [3], t7_nxt [3];
  logic  ovf7_r, ovf7_nxt;

  always_comb begin
    logic [DW:0] sf, st;
    logic        fl;
    fl = ovf6_r;
    for (int i = 0; i < 3; i++) begin
      sf = sat_fn(XW'(a6_r[i]) - XW'(b6_r[i]));
      st = sat_fn(XW'(c6_r[i]) + XW'(d6_r[i]));
      fl = fl | sf[DW] | st[DW];
      f7_nxt[i] = sf[DW-1:0];
      t7_nxt[i] = st[DW-1:0];
    end
    ovf7_nxt = fl;
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      f7_r   <= f7_nxt;
      t7_r   <= t7_nxt;
      ovf7_r <= ovf7_nxt;
    end
  end

  assign out_force_x  = f7_r[0];
  assign out_force_y  = f7_r[1];
  assign out_force_z  = f7_r[2];
  assign out_torque_x = t7_r[0];
  assign out_torque_y = t7_r[1];
  assign out_torque_z = t7_r[2];
  assign out_overflow = ovf7_r;

  // ---------------- assertions ----------------
  a_empty_out_all_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[NS] |-> (&en))
    else $error("pipeline held back although output register is empty");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[1])
    else $error("accepted transaction missing from first stage");

  a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS-1] && en[NS]) |=> out_valid)
    else $error("transaction lost between final stages");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_force_x) &&
      $stable(out_force_y) && $stable(out_force_z) && $stable(out_torque_x) &&
      $stable(out_torque_y) && $stable(out_torque_z) && $stable(out_overflow)))
    else $error("stalled output transaction changed");

endmodule
